[rtl/effector_sensitivity_serializer_defines.svh]
// Assertion macros used by the checker file of the sensitivity serializer.
// Depends on nothing; include by bare file name.
`ifndef EFFECTOR_SENSITIVITY_SERIALIZER_DEFINES_SVH
`define EFFECTOR_SENSITIVITY_SERIALIZER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define ESENS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ESENS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/esens_pkg.sv]
// Shared types, codes and the frame encoding of the sensitivity serializer.
// No dependencies.
package esens_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] sensitivity;
  } in_item_t;

  typedef struct packed {
    logic level;
    logic error;
    logic last;
  } out_item_t;

  // Command selector codes.
  localparam logic [1:0] FUNC_ERASE   = 2'd0;
  localparam logic [1:0] FUNC_PROGRAM = 2'd1;

  // Configuration register indexes and reset values.
  localparam logic REG_PROGRAM_BYTE = 1'b0;
  localparam logic REG_ERASE_BYTE   = 1'b1;
  localparam logic [7:0] PROGRAM_BYTE_RESET = 8'd105;
  localparam logic [7:0] ERASE_BYTE_RESET   = 8'd131;

  localparam int CFG_DATA_WIDTH = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Frame geometry.
  localparam logic [3:0] LAST_SLOT = 4'd13;
  localparam logic [1:0] LAST_FRAME_ERASE   = 2'd1;
  localparam logic [1:0] LAST_FRAME_PROGRAM = 2'd2;

  typedef enum logic [1:0] {
    KIND_ERASE,
    KIND_PROGRAM,
    KIND_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] sensitivity;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } back_state_t;

  // Line level of one slot of the frame that carries byte v.
  function automatic logic frame_level(input logic [7:0] v, input logic [3:0] slot);
    logic lvl;
    case (slot)
      4'd0, 4'd1, 4'd3: lvl = 1'b0;
      4'd2:  lvl = 1'b1;
      4'd4:  lvl = v[7];
      4'd5:  lvl = v[6];
      4'd6:  lvl = v[5];
      4'd7:  lvl = v[4];
      4'd8:  lvl = ~v[4];
      4'd9:  lvl = v[3];
      4'd10: lvl = v[2];
      4'd11: lvl = v[1];
      4'd12: lvl = v[0];
      default: lvl = ~v[0];
    endcase
    return lvl;
  endfunction

endpackage

[rtl/esens_front.sv]
// Front part: accepts command items and classifies them into queue entries.
// Depends on esens_pkg.
module esens_front
  import esens_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     q_ready,
  output logic     q_push,
  output cmd_t     q_cmd
);

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // Unused selector codes fall into the error class.
  always_comb begin
    q_cmd.sensitivity = in_item.sensitivity;
    case (in_item.func)
      FUNC_ERASE:   q_cmd.kind = KIND_ERASE;
      FUNC_PROGRAM: q_cmd.kind = KIND_PROGRAM;
      default:      q_cmd.kind = KIND_ERROR;
    endcase
  end

endmodule

[rtl/esens_queue.sv]
// Short command queue between the front and back parts.
// Depends on esens_pkg.
module esens_queue
  import esens_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_COUNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/esens_back.sv]
// Back part: slot sequencer that serializes one command into line-level items.
// Depends on esens_pkg.
module esens_back
  import esens_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  logic [7:0] program_byte,
  input  logic [7:0] erase_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  back_state_t state, state_next;
  cmd_kind_t   kind, kind_next;
  logic [7:0]  sens, sens_next;
  logic [1:0]  frame, frame_next;
  logic [3:0]  slot, slot_next;
  logic        valid_q, valid_next;
  out_item_t   item_q, item_next;

  logic       slot_free;
  logic [7:0] cur_byte;
  logic [1:0] final_frame;
  logic       final_slot;

  assign slot_free = ~valid_q | out_ready;
  assign out_valid = valid_q;
  assign out_item  = item_q;

  always_comb begin
    case (frame)
      2'd0:    cur_byte = (kind == KIND_ERASE) ? erase_byte : program_byte;
      2'd1:    cur_byte = (kind == KIND_ERASE) ? erase_byte : sens;
      default: cur_byte = ~sens;
    endcase
  end

  assign final_frame = (kind == KIND_ERASE) ? LAST_FRAME_ERASE : LAST_FRAME_PROGRAM;
  assign final_slot  = (slot == LAST_SLOT) && (frame == final_frame);

  always_comb begin
    state_next = state;
    kind_next  = kind;
    sens_next  = sens;
    frame_next = frame;
    slot_next  = slot;
    valid_next = valid_q & ~out_ready;
    item_next  = item_q;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          kind_next  = q_cmd.kind;
          sens_next  = q_cmd.sensitivity;
          frame_next = '0;
          slot_next  = '0;
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (slot_free) begin
          valid_next = 1'b1;
          if (kind == KIND_ERROR) begin
            item_next  = '{level: 1'b0, error: 1'b1, last: 1'b1};
            state_next = ST_IDLE;
          end else begin
            item_next = '{level: frame_level(cur_byte, slot), error: 1'b0,
                          last: final_slot};
            if (final_slot) begin
              state_next = ST_IDLE;
            end else if (slot == LAST_SLOT) begin
              slot_next  = '0;
              frame_next = frame + 1'b1;
            end else begin
              slot_next = slot + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state   <= state_next;
      valid_q <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind   <= kind_next;
    sens   <= sens_next;
    frame  <= frame_next;
    slot   <= slot_next;
    item_q <= item_next;
  end

endmodule

[rtl/effector_sensitivity_serializer.sv]
// Top level of the probe sensitivity serializer: configuration registers,
// front part, command queue and back part. Depends on esens_pkg and the esens_* modules.
//
//   Channel  Direction  Handshake              Carries
//   in       input      in_valid / in_ready    in_item_t: func, sensitivity
//   out      output     out_valid / out_ready  out_item_t: level, error, last
//   cfg      input      cfg_we (no wait)       cfg_index, cfg_data
//
// The back part's slot sequencer puts out one slot per cycle while out is not
// stalled: a program command yields 42 slots, an erase command 28, a no-option
// command 1, and each command passes through the idle state to leave the queue.
// Reset (rst, synchronous) empties the queue, idles the sequencer, drops
// out_valid and restores both magic bytes.
// A stall on out holds the pending item; the queue keeps taking commands
// until it is full, then in_ready drops.
module effector_sensitivity_serializer
  import esens_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_item,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  logic [7:0] program_byte;
  logic [7:0] erase_byte;

  logic q_ready;
  logic q_push;
  cmd_t q_in_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_out_cmd;

  // Magic bytes. The user must send writes only while the block is idle; the block
  // does not enforce this. The back part reads them directly while it serializes.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_byte <= PROGRAM_BYTE_RESET;
      erase_byte   <= ERASE_BYTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROGRAM_BYTE: program_byte <= cfg_data;
        REG_ERASE_BYTE:   erase_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front decodes each accepted item into an erase, program or error command.
  esens_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_cmd    (q_in_cmd)
  );

  // The queue lets the front keep accepting while the back part is busy.
  esens_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_out_cmd)
  );

  // The back part walks frames and slots and drives the output register.
  esens_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_out_cmd),
    .q_pop        (q_pop),
    .program_byte (program_byte),
    .erase_byte   (erase_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item)
  );

endmodule

[rtl/esens_checker.sv]
// Port-level checks of the sensitivity serializer, bound to the top level.
// Depends on esens_pkg and effector_sensitivity_serializer_defines.svh.
`include "effector_sensitivity_serializer_defines.svh"

module esens_checker
  import esens_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `ESENS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item), "output item changed while stalled")

  `ESENS_ASSERT(a_error_form, clk, rst, out_valid && out_item.error |-> out_item.last && !out_item.level, "error item is not a lone low final item")

  `ESENS_ASSERT(a_frame_start_low, clk, rst, out_valid && out_ready && out_item.last |=> !out_valid || !out_item.level, "command does not start with a low slot")

  `ESENS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "output valid right after reset")

endmodule

bind effector_sensitivity_serializer esens_checker u_checker (.*);

[tb/sv/esens_line_monitor.sv]
`timescale 1ns / 1ps
// Watches the command, line and register ports of the sensitivity serializer,
// predicts every bit slot and compares it. Depends on esens_pkg.
module esens_line_monitor
  import esens_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  in_item_t                  in_item,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  out_item_t                 out_item,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);

  out_item_t  expected_slots[$];
  logic [7:0] program_copy;
  logic [7:0] erase_copy;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: line slot mismatch: %s", $time, what);
    fail_count++;
  endtask

  // A frame is a start pattern of 0,0,1,0 followed by the two nibbles, each
  // closed by the complement of its lowest bit. Slots leave MSB first.
  function automatic void queue_frame(input logic [7:0] b, input logic final_frame);
    logic [13:0] pattern;
    out_item_t   slot;
    pattern = {2'b00, 1'b1, 1'b0, b[7:4], ~b[4], b[3:0], ~b[0]};
    for (int i = 13; i >= 0; i--) begin
      slot.level = pattern[i];
      slot.error = 1'b0;
      slot.last  = final_frame && (i == 0);
      expected_slots.push_back(slot);
    end
  endfunction

  function automatic void queue_command(input in_item_t cmd);
    out_item_t slot;
    case (cmd.func)
      FUNC_ERASE: begin
        queue_frame(erase_copy, 1'b0);
        queue_frame(erase_copy, 1'b1);
      end
      FUNC_PROGRAM: begin
        queue_frame(program_copy, 1'b0);
        queue_frame(cmd.sensitivity, 1'b0);
        queue_frame(8'd255 - cmd.sensitivity, 1'b1);
      end
      default: begin
        // No option given: a single flagged error slot, line held low.
        slot.level = 1'b0;
        slot.error = 1'b1;
        slot.last  = 1'b1;
        expected_slots.push_back(slot);
      end
    endcase
  endfunction

  task automatic check_slot(input out_item_t got);
    out_item_t want;
    if (expected_slots.size() == 0) begin
      report_mismatch($sformatf("slot %b with nothing expected", got));
    end else begin
      want = expected_slots.pop_front();
      if (got.level !== want.level)
        report_mismatch($sformatf("level %b, expected %b", got.level, want.level));
      if (got.error !== want.error)
        report_mismatch($sformatf("error %b, expected %b", got.error, want.error));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      program_copy = PROGRAM_BYTE_RESET;
      erase_copy   = ERASE_BYTE_RESET;
      expected_slots.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PROGRAM_BYTE) program_copy = cfg_data;
        else if (cfg_index == REG_ERASE_BYTE) erase_copy = cfg_data;
      end
      // A slot never belongs to a command taken at the same edge.
      if (out_valid && out_ready) check_slot(out_item);
      if (in_valid && in_ready) queue_command(in_item);
    end
    pending <= expected_slots.size();
  end

endmodule

[tb/sv/effector_sensitivity_serializer_test.sv]
`timescale 1ns / 1ps
// Testbench top for the probe sensitivity serializer: clock, reset, command and
// register stimulus, a stalling line receiver and the verdict.
// Depends on esens_pkg, effector_sensitivity_serializer and esens_line_monitor.
module effector_sensitivity_serializer_test;
  import esens_pkg::*;

  // Selector values that carry no option; the package names only the two real ones.
  localparam logic [1:0] FUNC_NONE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int LONG_HOLD       = 400;
  localparam int IDLE_LIMIT      = 3000;
  localparam int RANDOM_PHASES   = 4;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int TAIL_CYCLES     = 60;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_we    = 1'b0;
  logic                      cfg_index = REG_PROGRAM_BYTE;
  logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // The sender skips its gaps while no_gaps is set. hold_request asks the
  // receiver for one long stall so that the command queue fills and the
  // block drops in_ready.
  bit no_gaps      = 1'b0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  effector_sensitivity_serializer DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  esens_line_monitor line_monitor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Idle lengths for both sides: often none, mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Mostly real commands, since those drive the long slot sequences; the
  // no-option selectors still show up often enough to be exercised.
  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) return FUNC_PROGRAM;
    if (r < 80) return FUNC_ERASE;
    if (r < 92) return FUNC_NONE;
    return FUNC_UNUSED;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one command and holds it until taken. Valid is only lowered when
  // a gap follows, so back-to-back commands keep it high without a glitch.
  task automatic send_command(input logic [1:0] f, input logic [7:0] s);
    int gap;
    in_item  <= '{func: f, sensitivity: s};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every predicted slot has come out.
  // Every command yields at least one slot, so an empty store means idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes the program byte and then the erase byte; only called when idle.
  task automatic write_config(input logic [7:0] prog_byte, input logic [7:0] erase_byte);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PROGRAM_BYTE;
    cfg_data  <= prog_byte;
    @(posedge clk);
    cfg_index <= REG_ERASE_BYTE;
    cfg_data  <= erase_byte;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: runs of ready broken by random stalls, plus one long hold-off
  // counted here while the sender keeps pushing commands.
  initial begin : receiver
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 120)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: too many cycles with no item moving on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("effector_sensitivity_serializer_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] prog_byte;
    logic [7:0] erase_byte;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed commands at the reset magic bytes: both real commands, the
    // sensitivity extremes and single-bit values, both no-option selectors,
    // and an erase whose sensitivity field must be ignored.
    send_command(FUNC_ERASE, 8'h00);
    send_command(FUNC_PROGRAM, 8'h00);
    send_command(FUNC_PROGRAM, 8'hFF);
    send_command(FUNC_PROGRAM, 8'h80);
    send_command(FUNC_PROGRAM, 8'h01);
    send_command(FUNC_PROGRAM, 8'h10);
    send_command(FUNC_PROGRAM, 8'hEF);
    send_command(FUNC_PROGRAM, 8'h55);
    send_command(FUNC_NONE, 8'h00);
    send_command(FUNC_UNUSED, 8'hFF);
    send_command(FUNC_ERASE, 8'hFF);
    send_command(FUNC_NONE, 8'hAA);
    drain();

    // Magic bytes at their extremes, both ways round.
    write_config(8'h00, 8'hFF);
    send_command(FUNC_PROGRAM, 8'hAA);
    send_command(FUNC_ERASE, 8'h5A);
    send_command(FUNC_NONE, 8'h3C);
    drain();
    write_config(8'hFF, 8'h00);
    send_command(FUNC_PROGRAM, 8'h0F);
    send_command(FUNC_ERASE, 8'h00);
    send_command(FUNC_UNUSED, 8'h00);
    drain();

    // Random phases, each under its own magic bytes. The second phase opens
    // with a long receiver stall and a gapless burst to fill the queue; the
    // last one goes back to the reset values.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      prog_byte  = pick_byte();
      erase_byte = pick_byte();
      if (p == RANDOM_PHASES - 1) begin
        prog_byte  = PROGRAM_BYTE_RESET;
        erase_byte = ERASE_BYTE_RESET;
      end
      write_config(prog_byte, erase_byte);
      if (p == 1) begin
        hold_request = 1'b1;
        no_gaps      = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 30) no_gaps = 1'b0;
        send_command(pick_func(), 8'($urandom_range(0, 255)));
      end
      no_gaps = 1'b0;
      drain();
    end

    // Let any stray slot show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("effector_sensitivity_serializer_test: PASS");
    end else begin
      $display("effector_sensitivity_serializer_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/esens_pkg.sv
rtl/esens_front.sv
rtl/esens_queue.sv
rtl/esens_back.sv
rtl/effector_sensitivity_serializer.sv
rtl/esens_checker.sv
tb/sv/esens_line_monitor.sv
tb/sv/effector_sensitivity_serializer_test.sv
